/* rtl/vmc_pkg.sv */
// ----------------------------------------------------------------------------
// vmc_pkg
// Shared constants for the 2D vector magnitude clamp.
// ----------------------------------------------------------------------------
package vmc_pkg;

   localparam int MAX_MAG_WIDTH = 15;
   localparam logic [MAX_MAG_WIDTH-1:0] MAX_MAG_RESET = 15'd32767;

endpackage

/* rtl/vmc_req_if.sv */
// ----------------------------------------------------------------------------
// vmc_req_if
// Request channel: one 2D vector per transfer.
// ----------------------------------------------------------------------------
interface vmc_req_if #(
   parameter int COMP_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COMP_WIDTH-1:0] x_in;
   logic signed [COMP_WIDTH-1:0] y_in;

   modport source (output valid, x_in, y_in, input ready);
   modport sink   (input valid, x_in, y_in, output ready);
endinterface

/* rtl/vmc_rsp_if.sv */
// ----------------------------------------------------------------------------
// vmc_rsp_if
// Response channel: one clamped vector and flag per transfer.
// ----------------------------------------------------------------------------
interface vmc_rsp_if #(
   parameter int COMP_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COMP_WIDTH-1:0] x_out;
   logic signed [COMP_WIDTH-1:0] y_out;
   logic                         clamped;

   modport source (output valid, x_out, y_out, clamped, input ready);
   modport sink   (input valid, x_out, y_out, clamped, output ready);
endinterface

/* rtl/vmc_isqrt.sv */
// ----------------------------------------------------------------------------
// vmc_isqrt
// Pipelined integer square root, one result bit per stage, with side payload.
// ----------------------------------------------------------------------------
module vmc_isqrt #(
   parameter int W  = 16,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  logic            in_valid,
   input  logic [2*W-1:0]  in_n,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [W-1:0]    out_root,
   output logic [SW-1:0]   out_side
);
   localparam int NW = 2 * W;
   localparam int RW = W + 2;

   logic          valid_ff [W];
   logic [RW-1:0] rem_ff   [W];
   logic [W-1:0]  root_ff  [W];
   logic [NW-1:0] n_ff     [W];
   logic [SW-1:0] side_ff  [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic          cur_valid;
      logic [RW-1:0] cur_rem;
      logic [W-1:0]  cur_root;
      logic [NW-1:0] cur_n;
      logic [SW-1:0] cur_side;
      logic [RW-1:0] part;
      logic [RW-1:0] trial;
      logic          take;
      logic [RW-1:0] rem_in;
      logic [W-1:0]  root_in;

      if (k == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_rem   = '0;
         assign cur_root  = '0;
         assign cur_n     = in_n;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[k-1];
         assign cur_rem   = rem_ff[k-1];
         assign cur_root  = root_ff[k-1];
         assign cur_n     = n_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      // remainder stays below 2*root+1, so the top two bits drop out safely
      assign part    = {cur_rem[RW-3:0], cur_n[NW-1 -: 2]};
      assign trial   = {cur_root, 2'b01};
      assign take    = (part >= trial);
      assign rem_in  = take ? (part - trial) : part;
      assign root_in = {cur_root[W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            n_ff[k]    <= {cur_n[NW-3:0], 2'b00};
            side_ff[k] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[W-1];
   assign out_root  = root_ff[W-1];
   assign out_side  = side_ff[W-1];

endmodule

/* rtl/vmc_div2.sv */
// ----------------------------------------------------------------------------
// vmc_div2
// Pipelined restoring divider, two dividends over one divisor, one quotient
// bit per stage. Quotients must fit in W bits.
// ----------------------------------------------------------------------------
module vmc_div2 #(
   parameter int W  = 16,
   parameter int DW = 31,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  logic            in_valid,
   input  logic [DW-1:0]   in_num_a,
   input  logic [DW-1:0]   in_num_b,
   input  logic [W-1:0]    in_den,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [W-1:0]    out_quo_a,
   output logic [W-1:0]    out_quo_b,
   output logic [SW-1:0]   out_side
);
   logic          valid_ff [W];
   logic [W-1:0]  rema_ff  [W];
   logic [W-1:0]  remb_ff  [W];
   logic [W-1:0]  lowa_ff  [W];
   logic [W-1:0]  lowb_ff  [W];
   logic [W-1:0]  quoa_ff  [W];
   logic [W-1:0]  quob_ff  [W];
   logic [W-1:0]  den_ff   [W];
   logic [SW-1:0] side_ff  [W];

   logic [DW-1:0] hi_a;
   logic [DW-1:0] hi_b;

   assign hi_a = in_num_a >> W;
   assign hi_b = in_num_b >> W;

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic          cur_valid;
      logic [W-1:0]  cur_rema;
      logic [W-1:0]  cur_remb;
      logic [W-1:0]  cur_lowa;
      logic [W-1:0]  cur_lowb;
      logic [W-1:0]  cur_quoa;
      logic [W-1:0]  cur_quob;
      logic [W-1:0]  cur_den;
      logic [SW-1:0] cur_side;
      logic [W:0]    part_a;
      logic [W:0]    part_b;
      logic [W:0]    diff_a;
      logic [W:0]    diff_b;
      logic          take_a;
      logic          take_b;

      if (k == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_rema  = hi_a[W-1:0];
         assign cur_remb  = hi_b[W-1:0];
         assign cur_lowa  = in_num_a[W-1:0];
         assign cur_lowb  = in_num_b[W-1:0];
         assign cur_quoa  = '0;
         assign cur_quob  = '0;
         assign cur_den   = in_den;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[k-1];
         assign cur_rema  = rema_ff[k-1];
         assign cur_remb  = remb_ff[k-1];
         assign cur_lowa  = lowa_ff[k-1];
         assign cur_lowb  = lowb_ff[k-1];
         assign cur_quoa  = quoa_ff[k-1];
         assign cur_quob  = quob_ff[k-1];
         assign cur_den   = den_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      assign part_a = {cur_rema, cur_lowa[W-1]};
      assign part_b = {cur_remb, cur_lowb[W-1]};
      assign take_a = (part_a >= {1'b0, cur_den});
      assign take_b = (part_b >= {1'b0, cur_den});
      assign diff_a = take_a ? (part_a - {1'b0, cur_den}) : part_a;
      assign diff_b = take_b ? (part_b - {1'b0, cur_den}) : part_b;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rema_ff[k] <= diff_a[W-1:0];
            remb_ff[k] <= diff_b[W-1:0];
            lowa_ff[k] <= {cur_lowa[W-2:0], 1'b0};
            lowb_ff[k] <= {cur_lowb[W-2:0], 1'b0};
            quoa_ff[k] <= {cur_quoa[W-2:0], take_a};
            quob_ff[k] <= {cur_quob[W-2:0], take_b};
            den_ff[k]  <= cur_den;
            side_ff[k] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[W-1];
   assign out_quo_a = quoa_ff[W-1];
   assign out_quo_b = quob_ff[W-1];
   assign out_side  = side_ff[W-1];

endmodule

/* rtl/vector_magnitude_clamp_2d.sv */
// ----------------------------------------------------------------------------
// vector_magnitude_clamp_2d
// Limits the length of a signed Q8.8 2D vector to a programmable maximum.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one vector (x_in, y_in) per transfer; rsp returns x_out,
//   y_out and clamped, one per request, in order. csr_we/csr_wdata write the
//   maximum length (unsigned Q7.8); write it only while the block is empty.
//   Vectors no longer than the maximum pass unchanged with clamped low.
//   Longer ones are scaled by max/floor(sqrt(x*x+y*y)), truncated toward
//   zero, with clamped high.
// Pipeline:
//   A request passes through the magnitude, squares and compare registers,
//   COMP_WIDTH square-root stages (one root bit each), COMP_WIDTH divider
//   stages (one quotient bit each) and the response register. One vector per
//   cycle is accepted in steady state while the response is not stalled.
// Reset and stall:
//   Reset empties the pipeline and sets the maximum to 32767. A stalled
//   response freezes the whole pipeline; req.ready drops only while a
//   response is held and not taken, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vector_magnitude_clamp_2d #(
   parameter int COMP_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   vmc_req_if.sink                    req,
   vmc_rsp_if.source                  rsp,
   input  logic                       csr_we,
   input  logic [vmc_pkg::MAX_MAG_WIDTH-1:0] csr_wdata
);
   import vmc_pkg::*;

   localparam int W  = COMP_WIDTH;
   localparam int MW = MAX_MAG_WIDTH;
   localparam int PW = W + MW;
   localparam int CW = (2 * W > 2 * MW) ? 2 * W : 2 * MW;
   localparam int SQ_SW = 1 + 2 * W + 2 * PW;
   localparam int DV_SW = 1 + 2 * W;

   logic          enable;

   logic [MW-1:0]   max_ff;
   logic [2*MW-1:0] m2_ff;

   // stage 1: capture and magnitudes
   logic          v1_ff;
   logic [W-1:0]  x1_ff, y1_ff, ax1_ff, ay1_ff;
   logic [W-1:0]  xu, yu, ax1_in, ay1_in;

   // stage 2: products
   logic          v2_ff;
   logic [W-1:0]  x2_ff, y2_ff;
   logic [2*W-1:0] sx2_ff, sy2_ff;
   logic [PW-1:0] px2_ff, py2_ff;

   // stage 3: squared length and compare
   logic          v3_ff;
   logic [W-1:0]  x3_ff, y3_ff;
   logic [2*W-1:0] l2_3_ff;
   logic          clamp3_ff;
   logic [PW-1:0] px3_ff, py3_ff;
   logic [2*W-1:0] l2_3_in;

   logic             sq_valid;
   logic [W-1:0]     sq_root;
   logic [SQ_SW-1:0] sq_side;

   logic             dv_valid;
   logic [W-1:0]     qx, qy;
   logic [DV_SW-1:0] dv_side;
   logic             dv_clamp;
   logic [W-1:0]     dv_x, dv_y;

   logic          rsp_valid_ff;
   logic [W-1:0]  x_out_ff, y_out_ff;
   logic          clamped_ff;
   logic [W-1:0]  x_out_in, y_out_in;

   assign enable    = !rsp_valid_ff || rsp.ready;
   assign req.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_MAG_RESET;
         m2_ff  <= (2*MW)'(MAX_MAG_RESET) * (2*MW)'(MAX_MAG_RESET);
      end else begin
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
         m2_ff <= (2*MW)'(max_ff) * (2*MW)'(max_ff);
      end
   end

   assign xu     = req.x_in;
   assign yu     = req.y_in;
   assign ax1_in = xu[W-1] ? W'(~xu + 1'b1) : xu;
   assign ay1_in = yu[W-1] ? W'(~yu + 1'b1) : yu;
   assign l2_3_in = sx2_ff + sy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x1_ff  <= xu;
         y1_ff  <= yu;
         ax1_ff <= ax1_in;
         ay1_ff <= ay1_in;

         x2_ff  <= x1_ff;
         y2_ff  <= y1_ff;
         sx2_ff <= (2*W)'(ax1_ff) * (2*W)'(ax1_ff);
         sy2_ff <= (2*W)'(ay1_ff) * (2*W)'(ay1_ff);
         px2_ff <= PW'(ax1_ff) * PW'(max_ff);
         py2_ff <= PW'(ay1_ff) * PW'(max_ff);

         x3_ff     <= x2_ff;
         y3_ff     <= y2_ff;
         l2_3_ff   <= l2_3_in;
         clamp3_ff <= (CW'(l2_3_in) > CW'(m2_ff));
         px3_ff    <= px2_ff;
         py3_ff    <= py2_ff;
      end
   end

   vmc_isqrt #(
      .W  (W),
      .SW (SQ_SW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (v3_ff),
      .in_n      (l2_3_ff),
      .in_side   ({clamp3_ff, x3_ff, y3_ff, px3_ff, py3_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // pass-through vectors also run the divider; their quotients are unused
   vmc_div2 #(
      .W  (W),
      .DW (PW),
      .SW (DV_SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (sq_valid),
      .in_num_a  (sq_side[2*PW-1:PW]),
      .in_num_b  (sq_side[PW-1:0]),
      .in_den    (sq_root),
      .in_side   (sq_side[SQ_SW-1:2*PW]),
      .out_valid (dv_valid),
      .out_quo_a (qx),
      .out_quo_b (qy),
      .out_side  (dv_side)
   );

   assign dv_clamp = dv_side[DV_SW-1];
   assign dv_x     = dv_side[2*W-1:W];
   assign dv_y     = dv_side[W-1:0];

   always_comb begin
      if (dv_clamp) begin
         x_out_in = dv_x[W-1] ? W'(~qx + 1'b1) : qx;
         y_out_in = dv_y[W-1] ? W'(~qy + 1'b1) : qy;
      end else begin
         x_out_in = dv_x;
         y_out_in = dv_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_out_ff   <= x_out_in;
         y_out_ff   <= y_out_in;
         clamped_ff <= dv_clamp;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.x_out   = x_out_ff;
   assign rsp.y_out   = y_out_ff;
   assign rsp.clamped = clamped_ff;

endmodule

/* rtl/vmc_checker.sv */
// ----------------------------------------------------------------------------
// vmc_checker
// Port-level checks for the vector magnitude clamp, bound to the top level.
// ----------------------------------------------------------------------------
module vmc_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_clamped
);
   // pipeline empties on reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // only a held, untaken response can stall the request side
   a_ready_free : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled without a pending response");

   // a stall freezes the whole pipeline, so nothing is taken either
   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_clamped)))
      else $error("stalled response changed");

endmodule

bind vector_magnitude_clamp_2d vmc_checker u_vmc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_clamped (rsp.clamped)
);

/* bench/tb_vector_magnitude_clamp_2d.sv */
// ----------------------------------------------------------------------------
// tb_vector_magnitude_clamp_2d
// Self-checking bench for the 2D vector magnitude clamp: a directed table of
// edge vectors, vectors at maxima 0 and 1, then random vectors under several
// maximum lengths, responses compared with in-bench fixed-point predictions.
// ----------------------------------------------------------------------------
module tb_vector_magnitude_clamp_2d;
   timeunit 1ns;
   timeprecision 1ps;

   import vmc_pkg::*;

   localparam int CW       = 16;
   localparam int LATENCY  = 2*CW + 4;
   localparam int WATCHDOG = 5000;
   localparam int N_RANDOM = 930;

   typedef logic signed [CW-1:0]         comp_type;
   typedef logic [MAX_MAG_WIDTH-1:0]     mag_type;

   typedef struct packed {
      comp_type x;
      comp_type y;
      logic     clamped;
   } vec_res_type;

   typedef struct {
      comp_type    x;
      comp_type    y;
      logic        known;  // expected value typed in
      vec_res_type res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   mag_type csr_wdata = '0;

   vmc_req_if #(.COMP_WIDTH(CW)) req_if ();
   vmc_rsp_if #(.COMP_WIDTH(CW)) rsp_if ();

   vector_magnitude_clamp_2d #(.COMP_WIDTH(CW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mag_type     max_len;
   vec_res_type clamp_q[$];
   int          n_err = 0;
   int          n_rsp = 0;
   int          n_clamped = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;   // no idling in the last stretch

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic comp_type shrink(comp_type c, longint unsigned m,
                                       longint unsigned len);
      longint unsigned a, q;
      a = c[CW-1] ? longint'(-longint'(c)) : longint'(c);
      q = (a * m) / len;
      return c[CW-1] ? comp_type'(-q) : comp_type'(q);
   endfunction

   function automatic vec_res_type clamp_vec(comp_type x, comp_type y, mag_type m);
      longint unsigned ax, ay, l2, len;
      vec_res_type r;
      ax = x[CW-1] ? -longint'(x) : longint'(x);
      ay = y[CW-1] ? -longint'(y) : longint'(y);
      l2 = ax*ax + ay*ay;
      if (longint'(m)*longint'(m) >= l2) begin
         r = '{x, y, 1'b0};
      end else begin
         len = root_floor(l2);
         if (len == 0) len = 1;
         r = '{shrink(x, m, len), shrink(y, m, len), 1'b1};
      end
      return r;
   endfunction

   task automatic report(string what, vec_res_type got, vec_res_type exp);
      n_err++;
      $display("[%0t] MISMATCH %s: got x=%0d y=%0d c=%0b exp x=%0d y=%0d c=%0b",
               $realtime, what, got.x, got.y, got.clamped, exp.x, exp.y, exp.clamped);
   endtask

   // response checking and watchdog, sampled at the rising edge
   always @(posedge clock) begin
      vec_res_type got, exp;
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.x_out, rsp_if.y_out, rsp_if.clamped};
            n_rsp++;
            if (got.clamped) n_clamped++;
            if (clamp_q.size() == 0) begin
               report("unexpected transfer", got, got);
            end else begin
               exp = clamp_q.pop_front();
               if (got.x !== exp.x)             report("x_out", got, exp);
               if (got.y !== exp.y)             report("y_out", got, exp);
               if (got.clamped !== exp.clamped) report("clamped", got, exp);
            end
         end
      end
   end

   // sink side: random stall bursts
   initial begin
      int n;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         n = $urandom_range(1, 20);
         repeat (n) @(negedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            n = $urandom_range(1, 11);
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic send(comp_type x, comp_type y);
      int gap;
      clamp_q.push_back(clamp_vec(x, y, max_len));
      req_if.valid <= 1'b1;
      req_if.x_in  <= x;
      req_if.y_in  <= y;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (clamp_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic set_max(mag_type m);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we    <= 1'b0;
      max_len = m;
   endtask

   // random vector: mixes small, boundary and full-range components
   function automatic comp_type rand_comp();
      case ($urandom_range(0, 3))
         0: return comp_type'($urandom_range(0, 65535));
         1: return comp_type'($signed($urandom_range(0, 2047)) - 1024);
         2: return $urandom_range(0, 1) ? comp_type'(16'h8000) : comp_type'(16'h7fff);
         default: return comp_type'($signed($urandom_range(0, 16383)) - 8192);
      endcase
   endfunction

   dir_row_type dir_tab[$];
   mag_type     max_set[6] = '{15'd0, 15'd1, 15'd256, 15'd12345, 15'd32767, 15'd16384};

   initial begin
      req_if.valid = 1'b0;
      req_if.x_in  = '0;
      req_if.y_in  = '0;
      max_len = MAX_MAG_RESET;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // after reset, max 32767: only the corner, near-diagonal and -32768 axis vectors clamp
      dir_tab = '{
         '{16'sd0,      16'sd0,      1'b1, '{16'sd0, 16'sd0, 1'b0}},
         '{16'sd32767,  16'sd0,      1'b1, '{16'sd32767, 16'sd0, 1'b0}},
         '{-16'sd32768, 16'sd0,      1'b1, '{-16'sd32767, 16'sd0, 1'b1}},
         '{16'sd0,      -16'sd32768, 1'b1, '{16'sd0, -16'sd32767, 1'b1}},
         '{16'sd32767,  16'sd32767,  1'b0, '{'0, '0, 1'b0}},
         '{-16'sd32768, -16'sd32768, 1'b0, '{'0, '0, 1'b0}},
         '{16'sd32767,  -16'sd32768, 1'b0, '{'0, '0, 1'b0}},
         '{-16'sd1,     -16'sd1,     1'b1, '{-16'sd1, -16'sd1, 1'b0}},
         '{16'sd256,    -16'sd256,   1'b1, '{16'sd256, -16'sd256, 1'b0}},
         '{16'sd23170,  16'sd23170,  1'b0, '{'0, '0, 1'b0}}
      };
      foreach (dir_tab[i]) begin
         if (dir_tab[i].known) clamp_q.push_back(dir_tab[i].res);
         else clamp_q.push_back(clamp_vec(dir_tab[i].x, dir_tab[i].y, max_len));
         req_if.valid <= 1'b1;
         req_if.x_in  <= dir_tab[i].x;
         req_if.y_in  <= dir_tab[i].y;
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         @(negedge clock);
      end
      drain();

      // zero maximum: nonzero vectors collapse, zero passes
      set_max('0);
      send(16'sd0, 16'sd0);
      send(16'sd1, 16'sd0);
      send(-16'sd32768, 16'sd32767);
      send(16'sd0, -16'sd1);
      drain();
      set_max(15'd1);
      send(16'sd1, 16'sd1);
      send(16'sd0, -16'sd1);
      send(-16'sd5, 16'sd3);
      drain();

      for (int p = 0; p < 6; p++) begin
         set_max(p == 5 ? mag_type'($urandom_range(0, 32767)) : max_set[p]);
         for (int i = 0; i < N_RANDOM / 6; i++) begin
            if (p == 5 && i > 80) quiet = 1'b1;
            send(rand_comp(), rand_comp());
         end
         drain();
      end

      $display("Sent %0d vectors over %0d maximum lengths; %0d came back clamped.",
               n_rsp, 9, n_clamped);
      if (n_err == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG);
      $display("Watchdog expired after %0d idle cycles", WATCHDOG);
      $display("Test completed with failures");
      $finish;
   end
endmodule

/* sim.f */
rtl/vmc_pkg.sv
rtl/vmc_req_if.sv
rtl/vmc_rsp_if.sv
rtl/vmc_isqrt.sv
rtl/vmc_div2.sv
rtl/vector_magnitude_clamp_2d.sv
rtl/vmc_checker.sv
bench/tb_vector_magnitude_clamp_2d.sv
